// File: hdl/gck_pkg.sv
// ---------------------------------------------------------------------------
// gck_pkg: shared types and constants for the gated Kalman tracker
// Command codes, controller states and configuration register indexes.
// ---------------------------------------------------------------------------
package gck_pkg;

  localparam int CFG_W     = 31;
  localparam int IDX_W     = 3;
  localparam int Q_W       = 32;
  localparam int MEAS_W    = 27;
  localparam int DT_W      = 24;
  localparam int DIV_STEPS = 58;
  localparam int DIV_CNT_W = 6;

  localparam logic [IDX_W-1:0] REG_INIT_ANGLE = 3'd0;
  localparam logic [IDX_W-1:0] REG_INIT_RATE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL_Q    = 3'd2;
  localparam logic [IDX_W-1:0] REG_GATE       = 3'd3;
  localparam logic [IDX_W-1:0] REG_MEAS_VAR   = 3'd4;

  localparam logic [CFG_W-1:0] RST_INIT_ANGLE = 31'd838861;
  localparam logic [CFG_W-1:0] RST_INIT_RATE  = 31'd16777216;
  localparam logic [CFG_W-1:0] RST_ACCEL_Q    = 31'd0;
  localparam logic [CFG_W-1:0] RST_GATE       = 31'd50331648;
  localparam logic [CFG_W-1:0] RST_MEAS_VAR   = 31'd41943;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_PREDICT = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // datapath micro-ops, one per controller step
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_SEED, OP_CLEAR,
    OP_P_DT2, OP_P_DT3, OP_P_Q00, OP_P_Q01, OP_P_Q11, OP_P_DIV3,
    OP_P_ANG, OP_P_A1, OP_P_A2, OP_P_C1, OP_P_COMMIT,
    OP_M_S, OP_M_GATE, OP_M_DIVKA, OP_M_DIVKR,
    OP_M_U1, OP_M_U2, OP_M_U3, OP_M_U4, OP_M_U5, OP_M_U6,
    OP_M_U7, OP_M_U8, OP_M_U9, OP_M_COMMIT
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_DT2, ST_DT3, ST_Q00, ST_Q01, ST_Q11, ST_DIV3,
    ST_ANG, ST_A1, ST_A2, ST_C1, ST_PCOMMIT,
    ST_S, ST_GATE, ST_DIVKA, ST_DIVKAW, ST_DIVKR, ST_DIVKRW,
    ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8, ST_U9, ST_MCOMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic have_track;
    logic div_busy;
    logic q_zero;
    logic reject;
  } stat_t;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 64'sd2147483647;
    else if (v < -64'sd2147483648) sat32 = -64'sd2147483648;
    else sat32 = v;
  endfunction

  // product of two saturated operands, floor >> 24, saturated
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [31:0] sa, sb;
    logic signed [63:0] p;
    sa = 32'(sat32(a));
    sb = 32'(sat32(b));
    p = 64'(sa) * 64'(sb);
    qmul = sat32(p >>> 24);
  endfunction

endpackage

// File: hdl/gck_div.sv
// ---------------------------------------------------------------------------
// gck_div: radix-2 restoring divider
// Signed numerator over positive denominator, quotient truncated toward zero.
// ---------------------------------------------------------------------------
module gck_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic signed [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic signed [63:0] quot
);
  import gck_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, den_r, den_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt;
  logic [63:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r[62:0], q_r[63]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_nxt  = '0;
      // numerator magnitude is below 2^57, left-justify to skip leading zeros
      q_nxt    = (num < 0 ? 64'(-num) : 64'(num)) << (64 - DIV_STEPS);
      den_nxt  = den;
      neg_nxt  = num < 0;
    end else if (busy_r) begin
      q_nxt = {q_r[62:0], 1'b0};
      if (trial >= den_r) begin
        rem_nxt  = trial - den_r;
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial;
      end
      if (cnt_r == '0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// File: hdl/gck_datapath.sv
// ---------------------------------------------------------------------------
// gck_datapath: filter state, configuration and arithmetic steps
// One arithmetic step per micro-op, some with several products; gain divides go to the shared divider.
// ---------------------------------------------------------------------------
module gck_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gck_pkg::cmd_t      cmd,
  output gck_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [30:0]        cfg_data,
  input  logic [1:0]         in_kind,
  input  logic signed [26:0] in_meas,
  input  logic [23:0]        in_dt,
  input  logic signed [31:0] in_corr,
  input  logic               in_load,
  output logic [65:0]        res
);
  import gck_pkg::*;

  typedef logic signed [63:0] w_t;

  logic [CFG_W-1:0] ia_r, ir_r, aq_r, gs_r, rv_r;
  logic have_r, have_nxt, rs_r, rs_nxt;
  logic signed [31:0] ang_r, ang_nxt, rat_r, rat_nxt, p00_r, p00_nxt;
  logic signed [31:0] pc_r, pc_nxt, p11_r, p11_nxt;
  logic [1:0] kind_r;
  logic signed [26:0] meas_r;
  logic [23:0] dt_r;
  logic signed [31:0] corr_r;
  w_t t0_r, t0_nxt, t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;
  w_t t5_r, t5_nxt, t6_r, t6_nxt;
  logic rej_r, rej_nxt;
  logic [65:0] res_r;
  logic div_start;
  w_t div_num;
  logic [63:0] div_den;
  logic div_busy;
  w_t div_q;
  logic [61:0] gsq;
  logic [37:0] g2_r;
  logic [31:0] ar, ss;
  logic [63:0] r2, q3p;
  logic [69:0] gprod;
  w_t dt, r;

  gck_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ia_r <= RST_INIT_ANGLE; ir_r <= RST_INIT_RATE; aq_r <= RST_ACCEL_Q;
      gs_r <= RST_GATE; rv_r <= RST_MEAS_VAR;
      have_r <= 1'b0; ang_r <= '0; rat_r <= '0;
      p00_r <= '0; pc_r <= '0; p11_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_INIT_ANGLE: ia_r <= cfg_data;
          REG_INIT_RATE:  ir_r <= cfg_data;
          REG_ACCEL_Q:    aq_r <= cfg_data;
          REG_GATE:       gs_r <= cfg_data;
          REG_MEAS_VAR:   rv_r <= cfg_data;
          default: ;
        endcase
      end
      have_r <= have_nxt; ang_r <= ang_nxt; rat_r <= rat_nxt;
      p00_r <= p00_nxt; pc_r <= pc_nxt; p11_r <= p11_nxt;
    end
    if (in_load) begin
      kind_r <= in_kind; meas_r <= in_meas; dt_r <= in_dt; corr_r <= in_corr;
    end
    t0_r <= t0_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt; t3_r <= t3_nxt;
    t4_r <= t4_nxt; t5_r <= t5_nxt; t6_r <= t6_nxt;
    rej_r <= rej_nxt; rs_r <= rs_nxt;
    // squared gate width, registered from the gate register
    g2_r <= gsq[61:24];
    if (cmd.out_load)
      res_r <= {have_r, rs_r, have_r ? rat_r : 32'sd0, have_r ? ang_r : 32'sd0};
  end

  assign dt = w_t'({1'b0, dt_r});
  assign r  = w_t'({1'b0, rv_r});
  assign gsq = 62'(gs_r) * 62'(gs_r);
  // S is positive below 2^32 whenever the product is used
  assign ss = t0_r[31:0];
  assign ar = 32'(t1_r < 0 ? -t1_r : t1_r);
  assign r2 = 64'(ar) * 64'(ar);
  assign gprod = 70'(g2_r) * 70'(ss);
  // x/3 for 32-bit x as x * ceil(2^33/3) >> 33
  assign q3p = 64'(t2_r[31:0]) * 64'h0000_0000_AAAA_AAAB;

  // temporaries: t0 dt2 / S, t1 dt3 / residual, t3 ka, t4 kr, t2..t6 otherwise scratch
  always_comb begin
    have_nxt = have_r; ang_nxt = ang_r; rat_nxt = rat_r;
    p00_nxt = p00_r; pc_nxt = pc_r; p11_nxt = p11_r;
    t0_nxt = t0_r; t1_nxt = t1_r; t2_nxt = t2_r; t3_nxt = t3_r;
    t4_nxt = t4_r; t5_nxt = t5_r; t6_nxt = t6_r;
    rej_nxt = rej_r; rs_nxt = rs_r;
    div_start = 1'b0; div_num = t2_r; div_den = 64'(t0_r);
    case (cmd.op)
      OP_LOAD: begin
        rs_nxt = 1'b0;
        t2_nxt = '0; t3_nxt = '0; t4_nxt = '0;
      end
      OP_SEED: begin
        have_nxt = 1'b1;
        ang_nxt = 32'(w_t'(meas_r));
        rat_nxt = '0; p00_nxt = 32'({1'b0, ia_r}); pc_nxt = '0;
        p11_nxt = 32'({1'b0, ir_r});
        rs_nxt = (kind_r == KIND_MEASURE) && have_r;
      end
      OP_CLEAR: begin
        have_nxt = 1'b0; ang_nxt = '0; rat_nxt = '0;
        p00_nxt = '0; pc_nxt = '0; p11_nxt = '0;
        rs_nxt = 1'b0;
      end
      OP_P_DT2: t0_nxt = qmul(dt, dt);
      OP_P_DT3: t1_nxt = qmul(t0_r, dt);
      OP_P_Q00: t2_nxt = qmul(w_t'({1'b0, aq_r}), t1_r);
      OP_P_Q01: t3_nxt = qmul(w_t'({1'b0, aq_r}), t0_r) / 2;
      OP_P_Q11: t4_nxt = qmul(w_t'({1'b0, aq_r}), dt);
      OP_P_DIV3: t2_nxt = w_t'(q3p >> 33);
      OP_P_ANG: t5_nxt = sat32(w_t'(ang_r) + qmul(dt, w_t'(rat_r) - w_t'(corr_r)));
      OP_P_A1: t6_nxt = w_t'(p00_r) + qmul(dt, 2 * w_t'(pc_r));
      OP_P_A2: t6_nxt = sat32(t6_r + qmul(t0_r, w_t'(p11_r)) + t2_r);
      OP_P_C1: t1_nxt = sat32(w_t'(pc_r) + qmul(dt, w_t'(p11_r)) + t3_r);
      OP_P_COMMIT: begin
        ang_nxt = 32'(t5_r); p00_nxt = 32'(t6_r); pc_nxt = 32'(t1_r);
        p11_nxt = 32'(sat32(w_t'(p11_r) + t4_r));
      end
      OP_M_S: begin
        t0_nxt = w_t'(p00_r) + r;
        t1_nxt = w_t'(meas_r) - w_t'(ang_r);
      end
      OP_M_GATE: begin
        if (t0_r <= 0) rej_nxt = 1'b1;
        else if (gprod[69:64] != '0) rej_nxt = 1'b0;
        else rej_nxt = r2 > gprod[63:0];
        t2_nxt = w_t'(p00_r) <<< 24;
      end
      OP_M_DIVKA: div_start = 1'b1;
      OP_M_DIVKR: begin
        t3_nxt = sat32(div_q);
        div_start = 1'b1; div_num = w_t'(pc_r) <<< 24;
      end
      OP_M_U1: begin
        t4_nxt = sat32(div_q);
        t5_nxt = 64'sd16777216 - t3_r;
      end
      OP_M_U2: begin
        ang_nxt = 32'(sat32(w_t'(ang_r) + qmul(t3_r, t1_r)));
        rat_nxt = 32'(sat32(w_t'(rat_r) + qmul(t4_r, t1_r)));
        t6_nxt = qmul(t5_r, t5_r);
      end
      OP_M_U3: begin
        t6_nxt = qmul(t6_r, w_t'(p00_r));
        t2_nxt = qmul(t3_r, t3_r);
      end
      OP_M_U4: begin
        t6_nxt = sat32(t6_r + qmul(t2_r, r));
        t2_nxt = w_t'(pc_r) - qmul(t4_r, w_t'(p00_r));
      end
      OP_M_U5: begin
        t2_nxt = qmul(t5_r, t2_r);
        t1_nxt = qmul(t3_r, t4_r);
      end
      OP_M_U6: t2_nxt = sat32(t2_r + qmul(t1_r, r));
      OP_M_U7: t1_nxt = qmul(t4_r, t4_r);
      OP_M_U8: t1_nxt = qmul(t1_r, w_t'(p00_r) + r);
      OP_M_U9: t5_nxt = sat32(w_t'(p11_r) - qmul(t4_r, 2 * w_t'(pc_r)) + t1_r);
      OP_M_COMMIT: begin
        p00_nxt = 32'(t6_r); pc_nxt = 32'(t2_r); p11_nxt = 32'(t5_r);
      end
      default: ;
    endcase
  end

  assign stat.have_track = have_r;
  assign stat.div_busy   = div_busy;
  assign stat.q_zero     = (aq_r == '0) || (dt_r == '0);
  assign stat.reject     = rej_r;
  assign res = res_r;
endmodule

// File: hdl/gck_ctrl.sv
// ---------------------------------------------------------------------------
// gck_ctrl: sequencer for the tracker
// Walks propagate, gate, gain and covariance steps and owns the handshake.
// ---------------------------------------------------------------------------
module gck_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_kind,
  output logic           out_valid,
  input  logic           out_ready,
  output gck_pkg::cmd_t  cmd,
  input  gck_pkg::stat_t stat
);
  import gck_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    kind_r <= kind_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ov_nxt    = ov_r && !out_ready;
    cmd.op = OP_NOP;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        kind_nxt = in_kind;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.op = OP_LOAD;
        case (kind_t'(kind_r))
          KIND_CLEAR: begin
            cmd.op = OP_CLEAR; state_nxt = ST_OUT;
          end
          KIND_MEASURE: state_nxt = stat.have_track ? ST_DT2 : ST_S;
          KIND_PREDICT: state_nxt = stat.have_track ? ST_DT2 : ST_OUT;
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_DT2: begin cmd.op = OP_P_DT2; state_nxt = stat.q_zero ? ST_ANG : ST_DT3; end
      ST_DT3: begin cmd.op = OP_P_DT3; state_nxt = ST_Q00; end
      ST_Q00: begin cmd.op = OP_P_Q00; state_nxt = ST_Q01; end
      ST_Q01: begin cmd.op = OP_P_Q01; state_nxt = ST_Q11; end
      ST_Q11: begin cmd.op = OP_P_Q11; state_nxt = ST_DIV3; end
      ST_DIV3: begin cmd.op = OP_P_DIV3; state_nxt = ST_ANG; end
      ST_ANG: begin cmd.op = OP_P_ANG; state_nxt = ST_A1; end
      ST_A1: begin cmd.op = OP_P_A1; state_nxt = ST_A2; end
      ST_A2: begin cmd.op = OP_P_A2; state_nxt = ST_C1; end
      ST_C1: begin cmd.op = OP_P_C1; state_nxt = ST_PCOMMIT; end
      ST_PCOMMIT: begin
        cmd.op = OP_P_COMMIT;
        state_nxt = (kind_t'(kind_r) == KIND_MEASURE) ? ST_S : ST_OUT;
      end
      ST_S: begin
        cmd.op = stat.have_track ? OP_M_S : OP_SEED;
        state_nxt = stat.have_track ? ST_GATE : ST_OUT;
      end
      ST_GATE: begin cmd.op = OP_M_GATE; state_nxt = ST_DIVKA; end
      ST_DIVKA: begin
        if (stat.reject) begin
          cmd.op = OP_SEED; state_nxt = ST_OUT;
        end else begin
          cmd.op = OP_M_DIVKA; state_nxt = ST_DIVKAW;
        end
      end
      ST_DIVKAW: if (!stat.div_busy) state_nxt = ST_DIVKR;
      ST_DIVKR: begin cmd.op = OP_M_DIVKR; state_nxt = ST_DIVKRW; end
      ST_DIVKRW: if (!stat.div_busy) state_nxt = ST_U1;
      ST_U1: begin cmd.op = OP_M_U1; state_nxt = ST_U2; end
      ST_U2: begin cmd.op = OP_M_U2; state_nxt = ST_U3; end
      ST_U3: begin cmd.op = OP_M_U3; state_nxt = ST_U4; end
      ST_U4: begin cmd.op = OP_M_U4; state_nxt = ST_U5; end
      ST_U5: begin cmd.op = OP_M_U5; state_nxt = ST_U6; end
      ST_U6: begin cmd.op = OP_M_U6; state_nxt = ST_U7; end
      ST_U7: begin cmd.op = OP_M_U7; state_nxt = ST_U8; end
      ST_U8: begin cmd.op = OP_M_U8; state_nxt = ST_U9; end
      ST_U9: begin cmd.op = OP_M_U9; state_nxt = ST_MCOMMIT; end
      ST_MCOMMIT: begin cmd.op = OP_M_COMMIT; state_nxt = ST_OUT; end
      ST_OUT: if (!ov_r || out_ready) begin
        cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: hdl/gated_const_velocity_kalman.sv
// ---------------------------------------------------------------------------
// gated_const_velocity_kalman: two-state gated Kalman tracker
// Angle/rate tracker with gating, reseed and Joseph covariance update.
// ---------------------------------------------------------------------------
// One word in, one word out. A measure word with a track runs the
// propagate steps (the noise steps are skipped with no process noise),
// gate setup, then two gain divides in the shared radix-2 divider, and
// 11 update and output steps. Predict with a track runs the propagate
// steps only; a gate rejection reseeds in place of the gain and update
// steps. The next word is taken once the previous result is in the
// output register; a finished result waits in its last step while that
// register is still full.
module gated_const_velocity_kalman (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [87:0] in_tdata,   // measured_angle[26:0], time_step[50:27],
                                  // rate_correction[82:51], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // reseeded[0], track_valid[1]
  output logic [63:0] out_tdata   // angle_out[31:0], rate_out[63:32]
);
  import gck_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [65:0] res;

  gck_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .out_valid(out_tvalid), .out_ready(out_tready),
    .cmd(cmd), .stat(stat)
  );

  gck_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .in_kind(in_tuser), .in_meas(in_tdata[26:0]), .in_dt(in_tdata[50:27]),
    .in_corr(in_tdata[82:51]), .in_load(in_tvalid && in_tready), .res(res)
  );

  assign out_tdata = res[63:0];
  assign out_tuser = res[65:64];
endmodule

// File: tb/gck_track_checker.sv
// ---------------------------------------------------------------------------
// gck_track_checker: result checker for the gated Kalman tracker
// Watches the configuration port and both stream channels, carries its own
// copy of the filter state, predicts each result word and compares it.
// ---------------------------------------------------------------------------
module gck_track_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [87:0] in_tdata,   // measured_angle[26:0], time_step[50:27],
                                  // rate_correction[82:51], zero fill
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [1:0]  out_tuser,  // reseeded[0], track_valid[1]
  input  logic [63:0] out_tdata,  // angle_out[31:0], rate_out[63:32]
  output int          mismatches,
  output int          pending
);
  import gck_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] rate;
    logic        reseeded;
    logic        track;
  } estimate_t;

  estimate_t estimate_q[$];

  // register copies
  longint seed_angle_var, seed_rate_var, accel_q, gate_width, meas_var;
  // filter state copy
  bit     tracking;
  longint est_angle, est_rate, p_aa, p_ar, p_rr;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint sa, sb;
    sa = clamp32(a);
    sb = clamp32(b);
    return clamp32((sa * sb) >>> 24);
  endfunction

  function automatic longint fx_div(longint num, longint den);
    return clamp32((num * 64'sd16777216) / den);
  endfunction

  task automatic reseed_track(longint angle);
    tracking  = 1;
    est_angle = clamp32(angle);
    est_rate  = 0;
    p_aa      = seed_angle_var;
    p_ar      = 0;
    p_rr      = seed_rate_var;
  endtask

  task automatic time_update(longint dt, longint corr);
    longint dt2, dt3, n_aa, n_ar, n_rr, aa, ar, rr;
    dt2  = fx_mul(dt, dt);
    n_aa = 0;
    n_ar = 0;
    n_rr = 0;
    aa   = p_aa;
    ar   = p_ar;
    rr   = p_rr;
    if (dt != 0 && accel_q != 0) begin
      dt3  = fx_mul(dt2, dt);
      n_aa = fx_mul(accel_q, dt3) / 3;
      n_ar = fx_mul(accel_q, dt2) / 2;
      n_rr = fx_mul(accel_q, dt);
    end
    est_angle = clamp32(est_angle + fx_mul(dt, est_rate - corr));
    p_aa = clamp32(aa + fx_mul(dt, 2 * ar) + fx_mul(dt2, rr) + n_aa);
    p_ar = clamp32(ar + fx_mul(dt, rr) + n_ar);
    p_rr = clamp32(rr + n_rr);
  endtask

  function automatic bit outside_gate(longint residual, longint s);
    longint unsigned g2, mag, r2;
    g2  = (longint'(gate_width) * gate_width) >> 24;
    mag = residual < 0 ? -residual : residual;
    r2  = mag * mag;
    if (g2 != 0 && longint'(s) > 64'hFFFF_FFFF_FFFF_FFFF / g2) return 0;
    return r2 > g2 * longint'(s);
  endfunction

  // time update, gate, then gain and Joseph update; returns 1 on reseed
  task automatic meas_update(longint meas, longint dt, longint corr, output bit reseed);
    longint aa, ar, rr, s, residual, ka, kr, af;
    time_update(dt, corr);
    aa = p_aa;
    ar = p_ar;
    rr = p_rr;
    s = aa + meas_var;
    residual = meas - est_angle;
    reseed = 0;
    if (s <= 0 || outside_gate(residual, s)) begin
      reseed_track(meas);
      reseed = 1;
    end else begin
      ka = fx_div(aa, s);
      kr = fx_div(ar, s);
      est_angle = clamp32(est_angle + fx_mul(ka, residual));
      est_rate  = clamp32(est_rate + fx_mul(kr, residual));
      af = 64'sd16777216 - ka;
      p_aa = clamp32(fx_mul(fx_mul(af, af), aa) + fx_mul(fx_mul(ka, ka), meas_var));
      p_ar = clamp32(fx_mul(af, ar - fx_mul(kr, aa)) + fx_mul(fx_mul(ka, kr), meas_var));
      p_rr = clamp32(rr - fx_mul(kr, 2 * ar) + fx_mul(fx_mul(kr, kr), aa + meas_var));
    end
  endtask

  task automatic predict_word(kind_t kind, longint meas, longint dt, longint corr);
    estimate_t e;
    bit        reseed;
    reseed = 0;
    case (kind)
      KIND_MEASURE: begin
        if (!tracking) reseed_track(meas);
        else meas_update(meas, dt, corr, reseed);
      end
      KIND_PREDICT: begin
        if (tracking) time_update(dt, corr);
      end
      KIND_CLEAR: begin
        tracking = 0;
        est_angle = 0;
        est_rate = 0;
        p_aa = 0;
        p_ar = 0;
        p_rr = 0;
      end
      default: ;
    endcase
    e.angle    = tracking ? est_angle[31:0] : '0;
    e.rate     = tracking ? est_rate[31:0] : '0;
    e.reseeded = reseed;
    e.track    = tracking;
    estimate_q.push_back(e);
  endtask

  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      seed_angle_var = longint'(RST_INIT_ANGLE);
      seed_rate_var  = longint'(RST_INIT_RATE);
      accel_q        = longint'(RST_ACCEL_Q);
      gate_width     = longint'(RST_GATE);
      meas_var       = longint'(RST_MEAS_VAR);
      tracking = 0;
      est_angle = 0;
      est_rate = 0;
      p_aa = 0;
      p_ar = 0;
      p_rr = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_ANGLE: seed_angle_var = longint'(cfg_data);
          REG_INIT_RATE:  seed_rate_var  = longint'(cfg_data);
          REG_ACCEL_Q:    accel_q        = longint'(cfg_data);
          REG_GATE:       gate_width     = longint'(cfg_data);
          REG_MEAS_VAR:   meas_var       = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_word(kind_t'(in_tuser), longint'($signed(in_tdata[26:0])),
                     longint'(in_tdata[50:27]), longint'($signed(in_tdata[82:51])));
      if (out_tvalid && out_tready) begin
        if (estimate_q.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches <= mismatches + 1;
        end else begin
          want = estimate_q.pop_front();
          if (out_tdata[31:0] !== want.angle ||
              out_tdata[63:32] !== want.rate ||
              out_tuser[0] !== want.reseeded ||
              out_tuser[1] !== want.track)
            mismatches <= mismatches + 1;
          if (out_tdata[31:0] !== want.angle)
            $error("angle_out: expected %0d, got %0d",
                   $signed(want.angle), $signed(out_tdata[31:0]));
          if (out_tdata[63:32] !== want.rate)
            $error("rate_out: expected %0d, got %0d",
                   $signed(want.rate), $signed(out_tdata[63:32]));
          if (out_tuser[0] !== want.reseeded)
            $error("reseeded: expected %0d, got %0d", want.reseeded, out_tuser[0]);
          if (out_tuser[1] !== want.track)
            $error("track_valid: expected %0d, got %0d", want.track, out_tuser[1]);
        end
      end
    end
    pending <= estimate_q.size();
  end

endmodule

// File: tb/tb_gated_const_velocity_kalman.sv
// ---------------------------------------------------------------------------
// tb_gated_const_velocity_kalman: stimulus and verdict for the Kalman tracker
// Runs directed and random measure/predict/clear words over several register
// settings with random stalls on both channels; the checker does the compare.
// ---------------------------------------------------------------------------
module tb_gated_const_velocity_kalman;
  import gck_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [1:0]  out_tuser;
  logic [63:0] out_tdata;

  int mismatches, pending;
  logic in_fire = 0, out_fire = 0;
  bit quiet = 0;          // no idling on either side
  bit hold_off_req = 0;   // ask the receiver for one long stall
  int stalled_cycles = 0;

  always #1 clk = ~clk;

  gated_const_velocity_kalman dut (.*);

  gck_track_checker checker_i (.*);

  always @(posedge clk) begin
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
  end

  always @(posedge clk) begin
    if (in_fire || out_fire || !rst_n) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        out_tready = 0;
        hold--;
      end else if (quiet || $urandom_range(0, 5) != 0) begin
        out_tready = 1;
      end else begin
        out_tready = 0;
        hold = $urandom_range(1, 14) - 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_regs(logic [30:0] a, logic [30:0] r, logic [30:0] q,
                           logic [30:0] g, logic [30:0] m);
    @(negedge clk);
    in_tvalid = 0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_INIT_ANGLE, a);
    write_reg(REG_INIT_RATE, r);
    write_reg(REG_ACCEL_Q, q);
    write_reg(REG_GATE, g);
    write_reg(REG_MEAS_VAR, m);
  endtask

  // present one word from a falling edge and wait until it is taken
  task automatic send_word(kind_t kind, logic [26:0] meas, logic [23:0] dt,
                           logic [31:0] corr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = kind;
    in_tdata = {5'd0, corr, dt, meas};
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic random_word(int track_angle);
    kind_t       kind;
    logic [26:0] meas;
    logic [23:0] dt;
    logic [31:0] corr;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) kind = KIND_MEASURE;
    else if (pick < 87) kind = KIND_PREDICT;
    else if (pick < 94) kind = KIND_CLEAR;
    else kind = KIND_NONE;
    if ($urandom_range(0, 9) == 0) meas = 27'($urandom());
    else meas = 27'(track_angle + $signed($urandom_range(0, 400000)) - 200000);
    if ($urandom_range(0, 9) == 0) dt = 24'($urandom());
    else if ($urandom_range(0, 15) == 0) dt = '0;
    else dt = 24'($urandom_range(1, 1 << 19));
    if ($urandom_range(0, 9) == 0) corr = $urandom();
    else corr = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    send_word(kind, meas, dt, corr);
  endtask

  task automatic random_run(int count);
    int base;
    base = $signed($urandom_range(0, 40000000)) - 20000000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0)
        base = $signed($urandom_range(0, 40000000)) - 20000000;
      random_word(base);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1;

    // directed words under reset register values
    send_word(KIND_PREDICT, 27'h1234567, 24'hFFFFFF, 32'h7FFFFFFF);  // no track
    send_word(KIND_NONE, '0, '0, '0);
    send_word(KIND_MEASURE, 27'h3FFFFFF, 24'h000000, 32'h00000000);  // seed
    send_word(KIND_NONE, '0, '0, '0);
    send_word(KIND_MEASURE, 27'h3FFFF00, 24'h000000, 32'h00000000);  // zero dt
    send_word(KIND_MEASURE, 27'h4000000, 24'h010000, 32'h80000000);  // gate reject
    send_word(KIND_PREDICT, '0, 24'hFFFFFF, 32'h7FFFFFFF);
    send_word(KIND_PREDICT, '0, 24'hFFFFFF, 32'h80000000);
    send_word(KIND_MEASURE, 27'h4000000, 24'hFFFFFF, 32'hFFFFFFFF);
    send_word(KIND_CLEAR, 27'h7FFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_word(KIND_PREDICT, '0, 24'h100000, '0);
    send_word(KIND_MEASURE, 27'h0100000, 24'h100000, '0);
    send_word(KIND_MEASURE, 27'h0101000, 24'h100000, 32'h00100000);
    send_word(KIND_MEASURE, 27'h0102000, 24'h100000, 32'h00100000);
    send_word(KIND_PREDICT, '0, 24'h000000, '0);
    send_word(KIND_NONE, 27'h5555555, 24'hAAAAAA, 32'h55555555);

    random_run(100);
    hold_off_req = 1;   // receiver holds off; sender keeps offering
    random_run(160);

    load_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    random_run(230);
    load_regs(31'd1, 31'd1, 31'd0, 31'd1, 31'd1);
    send_word(KIND_MEASURE, 27'h0200000, '0, '0);
    send_word(KIND_MEASURE, 27'h0200001, 24'h000001, '0);
    random_run(230);
    load_regs(31'd838861, 31'd16777216, 31'd1677722, 31'd67108864, 31'd41943);
    random_run(230);
    load_regs(31'($urandom()), 31'($urandom()), 31'($urandom()), 31'($urandom()),
              31'($urandom()));
    random_run(200);
    load_regs(31'd8388608, 31'd4194304, 31'd167772, 31'd50331648, 31'd167772);
    quiet = 1;
    random_run(200);

    @(negedge clk);
    in_tvalid = 0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gck_pkg.sv
hdl/gck_div.sv
hdl/gck_datapath.sv
hdl/gck_ctrl.sv
hdl/gated_const_velocity_kalman.sv
tb/gck_track_checker.sv
tb/tb_gated_const_velocity_kalman.sv
